### sv/imh_pkg.sv
// Package for the indexed max-heap: entry layout, request and status codes,
// and the control word that the sequencer sends along the row of level cells.
// No dependencies.
package imh_pkg;

  localparam int LABEL_W     = 8;
  localparam int HEIGHT_W    = 31;
  localparam int LABEL_COUNT = 256;

  // Request kinds carried on in_req_type.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  // One heap entry: its label and its height key.
  typedef struct packed {
    logic [LABEL_W-1:0]  label;
    logic [HEIGHT_W-1:0] height;
  } entry_t;

  // Control word for the level cells; levels and addresses travel beside it.
  typedef struct packed {
    logic   wr_en;
    logic   rd_a_en;
    logic   rd_b_en;
    entry_t wr_data;
  } cell_cmd_t;

endpackage

### sv/indexed_max_heap.sv
// Indexed binary max-heap of labelled heights.
// Depends on imh_pkg, imh_label_table and imh_level_cell.
//
// Usage: present a request on in_req_type, in_entry_label and in_entry_height
// and raise start; the item is taken at a clock edge where start is high and
// busy is low. An insert places the height under the label and sifts it up; a
// remove takes the labelled entry out and returns its height. Exactly one
// result follows each item: out_valid is high for one cycle with out_status,
// out_removed_height, out_max_height and out_is_empty. The receiver cannot
// stall; the result must be taken in that cycle.
// A failed request ends after the label lookup. An insert climbs from the new
// last slot until it reaches the root or a parent stops it. A remove ends after
// the fetch when the removed entry was the last one; otherwise it moves the last
// entry into the hole and lets it climb, then descend. The heap is split into
// one cell per tree level, and each sift step reads a level memory and then
// compares and writes back. busy falls in the cycle in which out_valid is
// high, so the next item can enter then.
// Reset: rst_n clears the entry count and every label's valid bit at once; the
// heap is empty and ready right after reset.
module indexed_max_heap import imh_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_req_type,
  input  logic [LABEL_W-1:0]  in_entry_label,
  input  logic [HEIGHT_W-1:0] in_entry_height,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [HEIGHT_W-1:0] out_removed_height,
  output logic [HEIGHT_W-1:0] out_max_height,
  output logic                out_is_empty
);

  localparam int            SW     = $clog2(CAPACITY + 1);
  localparam int            LEVELS = SW;
  localparam int            LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [SW-1:0] CAP    = SW'(CAPACITY);
  localparam logic [SW-1:0] ROOT   = SW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_REM_LOAD,
    S_RISE_RD,
    S_RISE_CMP,
    S_SINK_RD,
    S_SINK_CMP
  } state_t;

  state_t              state_r, state_nxt;
  logic [SW-1:0]       count_r, count_nxt;
  logic [SW-1:0]       s_r, s_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  entry_t              e_r, e_nxt;
  logic                req_r, req_nxt;
  logic [LABEL_W-1:0]  label_r, label_nxt;
  logic [HEIGHT_W-1:0] removed_r, removed_nxt;
  logic [HEIGHT_W-1:0] root_r, root_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [HEIGHT_W-1:0] out_removed_r, out_removed_nxt;

  cell_cmd_t           cmd;
  logic [LW-1:0]       wr_lvl, rd_a_lvl, rd_b_lvl;
  logic [SW-1:0]       wr_slot, rd_a_slot, rd_b_slot;
  entry_t              chain_a [LEVELS+1];
  entry_t              chain_b [LEVELS+1];
  entry_t              rd_a, rd_b;

  logic                sol_re, sol_we, sol_wvld, sol_hit;
  logic [LABEL_W-1:0]  sol_wlabel;
  logic [SW-1:0]       sol_wslot, sol_slot;

  logic [SW-1:0]       count_inc, count_dec, parent_slot, child_slot;
  logic [SW:0]         c_slot;
  logic                c_in, c_has_right, pick_right;
  entry_t              child;

  // Tree level of a slot: the position of its leading one.
  function automatic logic [LW-1:0] lvl_of(input logic [SW-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < SW; i++) begin
      if (v[i]) r = LW'(i);
    end
    return r;
  endfunction

  // Label-to-slot lookup, read at the edge that accepts an item.
  imh_label_table #(.SW(SW)) u_labels (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (sol_re),
    .rd_label (in_entry_label),
    .rd_slot  (sol_slot),
    .rd_hit   (sol_hit),
    .wr_en    (sol_we),
    .wr_label (sol_wlabel),
    .wr_slot  (sol_wslot),
    .wr_vld   (sol_wvld)
  );

  // One cell per tree level; read data is handed down the row.
  assign chain_a[0] = '0;
  assign chain_b[0] = '0;
  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    localparam int CAW = (l == 0) ? 1 : l;
    imh_level_cell #(.LVL(l), .LW(LW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .wr_lvl    (wr_lvl),
      .wr_addr   (wr_slot[CAW-1:0]),
      .rd_a_lvl  (rd_a_lvl),
      .rd_a_addr (rd_a_slot[CAW-1:0]),
      .rd_b_lvl  (rd_b_lvl),
      .rd_b_addr (rd_b_slot[CAW-1:0]),
      .rd_a_in   (chain_a[l]),
      .rd_b_in   (chain_b[l]),
      .rd_a_out  (chain_a[l+1]),
      .rd_b_out  (chain_b[l+1])
    );
  end
  assign rd_a = chain_a[LEVELS];
  assign rd_b = chain_b[LEVELS];

  // Slot arithmetic for the sift steps.
  assign count_inc   = count_r + SW'(1);
  assign count_dec   = count_r - SW'(1);
  assign parent_slot = s_r >> 1;
  assign c_slot      = {s_r, 1'b0};
  assign c_in        = c_slot <= {1'b0, count_r};
  assign c_has_right = c_slot <  {1'b0, count_r};
  assign pick_right  = c_has_right && (rd_b.height > rd_a.height);
  assign child       = pick_right ? rd_b : rd_a;
  assign child_slot  = c_slot[SW-1:0] | SW'(pick_right);

  // Request sequencer: lookup, fetch, then a read state and a compare state per level.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    s_nxt           = s_r;
    lvl_nxt         = lvl_r;
    e_nxt           = e_r;
    req_nxt         = req_r;
    label_nxt       = label_r;
    removed_nxt     = removed_r;
    root_nxt        = root_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    cmd             = '0;
    wr_lvl          = lvl_r;
    wr_slot         = s_r;
    rd_a_lvl        = '0;
    rd_a_slot       = '0;
    rd_b_lvl        = '0;
    rd_b_slot       = '0;
    sol_re          = 1'b0;
    sol_we          = 1'b0;
    sol_wlabel      = label_r;
    sol_wslot       = s_r;
    sol_wvld        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt     = in_req_type;
          label_nxt   = in_entry_label;
          e_nxt       = '{label: in_entry_label, height: in_entry_height};
          removed_nxt = '0;
          sol_re      = 1'b1;
          state_nxt   = S_CHECK;
        end
      end

      S_CHECK: begin
        if (req_r == REQ_INSERT) begin
          if (sol_hit) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = ST_PRESENT;
            out_removed_nxt = '0;
            state_nxt       = S_IDLE;
          end else if (count_r == CAP) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = ST_FULL;
            out_removed_nxt = '0;
            state_nxt       = S_IDLE;
          end else begin
            count_nxt = count_inc;
            s_nxt     = count_inc;
            lvl_nxt   = lvl_of(count_inc);
            state_nxt = S_RISE_RD;
          end
        end else begin
          if (!sol_hit || (sol_slot > count_r)) begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = ST_ABSENT;
            out_removed_nxt = '0;
            state_nxt       = S_IDLE;
          end else begin
            // Fetch the removed entry and the last entry together.
            cmd.rd_a_en = 1'b1;
            rd_a_lvl    = lvl_of(sol_slot);
            rd_a_slot   = sol_slot;
            cmd.rd_b_en = 1'b1;
            rd_b_lvl    = lvl_of(count_r);
            rd_b_slot   = count_r;
            s_nxt       = sol_slot;
            lvl_nxt     = lvl_of(sol_slot);
            state_nxt   = S_REM_LOAD;
          end
        end
      end

      S_REM_LOAD: begin
        removed_nxt = rd_a.height;
        e_nxt       = rd_b;
        count_nxt   = count_dec;
        sol_we      = 1'b1;
        sol_wlabel  = label_r;
        sol_wvld    = 1'b0;
        if (s_r == count_r) begin
          // The removed entry was the last one; nothing moves.
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_removed_nxt = rd_a.height;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_RISE_RD;
        end
      end

      S_RISE_RD: begin
        if (s_r != ROOT) begin
          cmd.rd_a_en = 1'b1;
          rd_a_lvl    = lvl_r - LW'(1);
          rd_a_slot   = parent_slot;
          state_nxt   = S_RISE_CMP;
        end else if (req_r == REQ_INSERT) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_data     = e_r;
          sol_we          = 1'b1;
          sol_wlabel      = e_r.label;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_removed_nxt = removed_r;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_SINK_RD;
        end
      end

      S_RISE_CMP: begin
        if (e_r.height > rd_a.height) begin
          // Parent moves down into the hole.
          cmd.wr_en   = 1'b1;
          cmd.wr_data = rd_a;
          sol_we      = 1'b1;
          sol_wlabel  = rd_a.label;
          s_nxt       = parent_slot;
          lvl_nxt     = lvl_r - LW'(1);
          state_nxt   = S_RISE_RD;
        end else if (req_r == REQ_INSERT) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_data     = e_r;
          sol_we          = 1'b1;
          sol_wlabel      = e_r.label;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_removed_nxt = removed_r;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_SINK_RD;
        end
      end

      S_SINK_RD: begin
        if (c_in) begin
          cmd.rd_a_en = 1'b1;
          rd_a_lvl    = lvl_r + LW'(1);
          rd_a_slot   = c_slot[SW-1:0];
          cmd.rd_b_en = 1'b1;
          rd_b_lvl    = lvl_r + LW'(1);
          rd_b_slot   = c_slot[SW-1:0] | SW'(1);
          state_nxt   = S_SINK_CMP;
        end else begin
          cmd.wr_en       = 1'b1;
          cmd.wr_data     = e_r;
          sol_we          = 1'b1;
          sol_wlabel      = e_r.label;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_removed_nxt = removed_r;
          state_nxt       = S_IDLE;
        end
      end

      S_SINK_CMP: begin
        if (child.height > e_r.height) begin
          // Larger child moves up into the hole.
          cmd.wr_en   = 1'b1;
          cmd.wr_data = child;
          sol_we      = 1'b1;
          sol_wlabel  = child.label;
          s_nxt       = child_slot;
          lvl_nxt     = lvl_r + LW'(1);
          state_nxt   = S_SINK_RD;
        end else begin
          cmd.wr_en       = 1'b1;
          cmd.wr_data     = e_r;
          sol_we          = 1'b1;
          sol_wlabel      = e_r.label;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_removed_nxt = removed_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Keep a copy of the root height for the maximum report.
    if (cmd.wr_en && (wr_slot == ROOT)) begin
      root_nxt = cmd.wr_data.height;
    end
  end

  // State, working registers and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      out_status_r  <= ST_OK;
      out_removed_r <= '0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
      out_status_r  <= out_status_nxt;
      out_removed_r <= out_removed_nxt;
    end
    s_r       <= s_nxt;
    lvl_r     <= lvl_nxt;
    e_r       <= e_nxt;
    req_r     <= req_nxt;
    label_r   <= label_nxt;
    removed_r <= removed_nxt;
    root_r    <= root_nxt;
  end

  // Result ports.
  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_removed_height = out_removed_r;
  assign out_is_empty       = (count_r == '0);
  assign out_max_height     = (count_r != '0) ? root_r : '0;

`ifndef SYNTHESIS
  // A result is never shown while an item is still at work.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted item always occupies the block in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // Only a successful remove reports a removed height.
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_removed_height == '0))
    else $error("failed request reported a removed height");

  // The entry count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("entry count beyond capacity");
`endif

endmodule

### sv/imh_label_table.sv
// Label-to-slot table of the indexed max-heap, with a valid bit per label.
// Depends on imh_pkg for the label width and count.
module imh_label_table import imh_pkg::*; #(
  parameter int SW = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [LABEL_W-1:0] rd_label,
  output logic [SW-1:0]      rd_slot,
  output logic               rd_hit,
  input  logic               wr_en,
  input  logic [LABEL_W-1:0] wr_label,
  input  logic [SW-1:0]      wr_slot,
  input  logic               wr_vld
);

  logic [SW-1:0]          slot_mem [LABEL_COUNT];
  logic [LABEL_COUNT-1:0] vld_r;
  logic [SW-1:0]          rd_slot_r;
  logic                   rd_hit_r;

  // Slot storage; a label without its valid bit reads as absent.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_label] <= wr_slot;
    end
    if (rd_en) begin
      rd_slot_r <= slot_mem[rd_label];
    end
  end

  // Valid bits are cleared at once by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_label] <= wr_vld;
      end
      if (rd_en) begin
        rd_hit_r <= vld_r[rd_label];
      end
    end
  end

  assign rd_slot = rd_slot_r;
  assign rd_hit  = rd_hit_r;

endmodule

### sv/imh_level_cell.sv
// One level of the heap: the slots of that level in a small memory with one
// write port and two read ports. Read data rides a chain from cell to cell.
// Depends on imh_pkg for the entry and control types.
module imh_level_cell import imh_pkg::*; #(
  parameter int LVL = 0,
  parameter int LW  = 4,
  localparam int AW = (LVL == 0) ? 1 : LVL
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_cmd_t     cmd,
  input  logic [LW-1:0] wr_lvl,
  input  logic [AW-1:0] wr_addr,
  input  logic [LW-1:0] rd_a_lvl,
  input  logic [AW-1:0] rd_a_addr,
  input  logic [LW-1:0] rd_b_lvl,
  input  logic [AW-1:0] rd_b_addr,
  input  entry_t        rd_a_in,
  input  entry_t        rd_b_in,
  output entry_t        rd_a_out,
  output entry_t        rd_b_out
);

  // The root level uses a two-entry memory; slot 1 sits at address 1.
  localparam int            DEPTH  = 2 ** AW;
  localparam logic [LW-1:0] MY_LVL = LW'(LVL);

  entry_t mem [DEPTH];
  entry_t q_a_r;
  entry_t q_b_r;
  logic   sel_a_r;
  logic   sel_b_r;
  logic   wr_hit;
  logic   rd_a_hit;
  logic   rd_b_hit;

  assign wr_hit   = cmd.wr_en   && (wr_lvl   == MY_LVL);
  assign rd_a_hit = cmd.rd_a_en && (rd_a_lvl == MY_LVL);
  assign rd_b_hit = cmd.rd_b_en && (rd_b_lvl == MY_LVL);

  // Level storage with registered read data.
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_addr] <= cmd.wr_data;
    end
    if (rd_a_hit) begin
      q_a_r <= mem[rd_a_addr];
    end
    if (rd_b_hit) begin
      q_b_r <= mem[rd_b_addr];
    end
  end

  // Remember which cell owns the read data of the last cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_a_r <= 1'b0;
      sel_b_r <= 1'b0;
    end else begin
      sel_a_r <= rd_a_hit;
      sel_b_r <= rd_b_hit;
    end
  end

  // Put this cell's data on the chain or pass the neighbor's on.
  assign rd_a_out = sel_a_r ? q_a_r : rd_a_in;
  assign rd_b_out = sel_b_r ? q_b_r : rd_b_in;

endmodule
